### rtl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared widths, register codes and beat types for the segment
// intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

  // Coordinate and intermediate widths.
  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;        // endpoint differences
  localparam int PROD_BITS  = 2 * DIFF_BITS;         // products of differences
  localparam int DET_BITS   = PROD_BITS + 1;         // d, nl, nr (signed)
  localparam int MAG_BITS   = PROD_BITS;             // |d| and the adjusted nl
  localparam int QUO_BITS   = DIFF_BITS;             // quotient never exceeds |ldx|
  localparam int SCALE_BITS = MAG_BITS + QUO_BITS;   // nl * |ldx|

  // Configuration register file.
  localparam int LIMIT_BITS = 21;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1);
  localparam logic [ADDR_BITS-1:0]  REG_PARALLEL_LIMIT = ADDR_BITS'(0);

  // One input beat: the endpoints of both segments.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
  } sgi_in_t;

  // One result beat.
  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } sgi_out_t;

  // Side information that travels with an item through scaling and division.
  typedef struct packed {
    logic                         hit;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
  } sgi_tag_t;

endpackage

`default_nettype wire

### rtl/segment_intersection_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_top
// Segment pair intersection test with intersection point, fully pipelined.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Transfer
//   command   start, busy, operands            start high while busy low
//   result    done, result                     done high for one cycle
//   config    psel..pwdata, prdata, pready     access cycle with pready
//
// One item may enter every cycle; busy stays low. Each result passes
// four geometry stages, two multiply stages, one divider stage per
// quotient bit (25) and the output register. Reset clears the valid
// bits and sets parallel_limit to 1. Results cannot be held off, so
// the pipeline never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  sgi_pkg::sgi_in_t                    operands,
  output logic                                done,
  output sgi_pkg::sgi_out_t                   result,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [sgi_pkg::ADDR_BITS-1:0]       paddr,
  input  wire  [sgi_pkg::DATA_BITS-1:0]       pwdata,
  output logic [sgi_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);

  localparam int C = sgi_pkg::COORD_BITS;
  localparam int M = sgi_pkg::MAG_BITS;
  localparam int Q = sgi_pkg::QUO_BITS;
  localparam int L = sgi_pkg::LIMIT_BITS;

  logic [L-1:0]            parallel_limit;
  logic                    g_valid, s_valid, v_valid;
  sgi_pkg::sgi_tag_t       g_tag, s_tag, v_tag;
  logic [M-1:0]            g_nl, g_det, s_det;
  logic [Q-1:0]            g_mx, g_my, v_qx, v_qy;
  logic [sgi_pkg::SCALE_BITS-1:0] s_px, s_py;
  logic signed [Q:0]       off_x, off_y;
  logic signed [Q:0]       sum_x, sum_y;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_limit <= sgi_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite &&
                 paddr == sgi_pkg::REG_PARALLEL_LIMIT) begin
      parallel_limit <= pwdata[L-1:0];
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    if (paddr == sgi_pkg::REG_PARALLEL_LIMIT) begin
      prdata = {{(sgi_pkg::DATA_BITS-L){1'b0}}, parallel_limit};
    end
  end

  sgi_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .operands  (operands),
    .limit     (parallel_limit),
    .out_valid (g_valid),
    .tag       (g_tag),
    .nl_mag    (g_nl),
    .det_mag   (g_det),
    .mag_x     (g_mx),
    .mag_y     (g_my)
  );

  sgi_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_tag    (g_tag),
    .nl_mag    (g_nl),
    .in_det    (g_det),
    .mag_x     (g_mx),
    .mag_y     (g_my),
    .out_valid (s_valid),
    .out_tag   (s_tag),
    .out_det   (s_det),
    .prod_x    (s_px),
    .prod_y    (s_py)
  );

  sgi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_tag    (s_tag),
    .det       (s_det),
    .num_x     (s_px),
    .num_y     (s_py),
    .out_valid (v_valid),
    .out_tag   (v_tag),
    .quo_x     (v_qx),
    .quo_y     (v_qy)
  );

  // Apply the direction sign and add the start point.
  always_comb begin
    off_x = v_tag.neg_x ? -$signed({1'b0, v_qx}) : $signed({1'b0, v_qx});
    off_y = v_tag.neg_y ? -$signed({1'b0, v_qy}) : $signed({1'b0, v_qy});
    sum_x = $signed({{(Q+1-C){v_tag.base_x[C-1]}}, v_tag.base_x}) + off_x;
    sum_y = $signed({{(Q+1-C){v_tag.base_y[C-1]}}, v_tag.base_y}) + off_y;
  end

  // Output register; a miss reports zero coordinates.
  always_ff @(posedge clk) begin
    result.hit     <= v_tag.hit;
    result.cross_x <= v_tag.hit ? sum_x[C-1:0] : '0;
    result.cross_y <= v_tag.hit ? sum_y[C-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_valid;
    end
  end

endmodule

`default_nettype wire

### rtl/sgi_geom.sv
// ----------------------------------------------------------------------------
// sgi_geom
// Four-stage front end: differences and box test, products, determinant and
// numerators, then the hit decision with magnitudes for the scaling step.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_geom (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  input  sgi_pkg::sgi_in_t                      operands,
  input  wire  [sgi_pkg::LIMIT_BITS-1:0]        limit,
  output logic                                  out_valid,
  output sgi_pkg::sgi_tag_t                     tag,
  output logic [sgi_pkg::MAG_BITS-1:0]          nl_mag,
  output logic [sgi_pkg::MAG_BITS-1:0]          det_mag,
  output logic [sgi_pkg::DIFF_BITS-1:0]         mag_x,
  output logic [sgi_pkg::DIFF_BITS-1:0]         mag_y
);

  localparam int C = sgi_pkg::COORD_BITS;
  localparam int D = sgi_pkg::DIFF_BITS;
  localparam int P = sgi_pkg::PROD_BITS;
  localparam int T = sgi_pkg::DET_BITS;
  localparam int M = sgi_pkg::MAG_BITS;
  localparam int L = sgi_pkg::LIMIT_BITS;

  // Stage A registers.
  logic                a_valid, a_reject;
  logic signed [D-1:0] a_ldx, a_ldy, a_rdx, a_rdy, a_ox, a_oy;
  logic signed [C-1:0] a_bx, a_by;
  // Stage B registers.
  logic                b_valid, b_reject;
  logic signed [P-1:0] b_d1, b_d2, b_l1, b_l2, b_r1, b_r2;
  logic signed [D-1:0] b_ldx, b_ldy;
  logic signed [C-1:0] b_bx, b_by;
  // Stage C registers.
  logic                c_valid, c_reject;
  logic signed [T-1:0] c_d, c_nl, c_nr;
  logic signed [D-1:0] c_ldx, c_ldy;
  logic signed [C-1:0] c_bx, c_by;

  // Stage A combinational signals.
  logic signed [C-1:0] lminx, lmaxx, lminy, lmaxy, rminx, rmaxx, rminy, rmaxy;
  logic                reject_next;
  // Stage D combinational signals.
  logic                d_neg, in_l, in_r, hit_next;
  logic signed [T-1:0] ad_full;
  logic signed [T:0]   nl_ext, nr_ext, nl_adj, nr_adj, ad_ext;

  // Bounding box extents of both segments.
  always_comb begin
    lminx = (operands.first_start_x < operands.first_end_x) ?
            operands.first_start_x : operands.first_end_x;
    lmaxx = (operands.first_start_x > operands.first_end_x) ?
            operands.first_start_x : operands.first_end_x;
    lminy = (operands.first_start_y < operands.first_end_y) ?
            operands.first_start_y : operands.first_end_y;
    lmaxy = (operands.first_start_y > operands.first_end_y) ?
            operands.first_start_y : operands.first_end_y;
    rminx = (operands.second_start_x < operands.second_end_x) ?
            operands.second_start_x : operands.second_end_x;
    rmaxx = (operands.second_start_x > operands.second_end_x) ?
            operands.second_start_x : operands.second_end_x;
    rminy = (operands.second_start_y < operands.second_end_y) ?
            operands.second_start_y : operands.second_end_y;
    rmaxy = (operands.second_start_y > operands.second_end_y) ?
            operands.second_start_y : operands.second_end_y;
    reject_next = (lminx > rmaxx) || (lmaxx < rminx) ||
                  (lminy > rmaxy) || (lmaxy < rminy);
  end

  // Stage A: differences and box rejection.
  always_ff @(posedge clk) begin
    a_reject <= reject_next;
    a_ldx <= $signed({operands.first_end_x[C-1], operands.first_end_x}) -
             $signed({operands.first_start_x[C-1], operands.first_start_x});
    a_ldy <= $signed({operands.first_end_y[C-1], operands.first_end_y}) -
             $signed({operands.first_start_y[C-1], operands.first_start_y});
    a_rdx <= $signed({operands.second_end_x[C-1], operands.second_end_x}) -
             $signed({operands.second_start_x[C-1], operands.second_start_x});
    a_rdy <= $signed({operands.second_end_y[C-1], operands.second_end_y}) -
             $signed({operands.second_start_y[C-1], operands.second_start_y});
    a_ox  <= $signed({operands.first_start_x[C-1], operands.first_start_x}) -
             $signed({operands.second_start_x[C-1], operands.second_start_x});
    a_oy  <= $signed({operands.first_start_y[C-1], operands.first_start_y}) -
             $signed({operands.second_start_y[C-1], operands.second_start_y});
    a_bx <= operands.first_start_x;
    a_by <= operands.first_start_y;
  end

  // Stage B: the six cross products.
  always_ff @(posedge clk) begin
    b_reject <= a_reject;
    b_d1 <= a_rdy * a_ldx;
    b_d2 <= a_rdx * a_ldy;
    b_l1 <= a_rdx * a_oy;
    b_l2 <= a_rdy * a_ox;
    b_r1 <= a_ldx * a_oy;
    b_r2 <= a_ldy * a_ox;
    b_ldx <= a_ldx;
    b_ldy <= a_ldy;
    b_bx <= a_bx;
    b_by <= a_by;
  end

  // Stage C: determinant and both numerators.
  always_ff @(posedge clk) begin
    c_reject <= b_reject;
    c_d  <= $signed({b_d1[P-1], b_d1}) - $signed({b_d2[P-1], b_d2});
    c_nl <= $signed({b_l1[P-1], b_l1}) - $signed({b_l2[P-1], b_l2});
    c_nr <= $signed({b_r1[P-1], b_r1}) - $signed({b_r2[P-1], b_r2});
    c_ldx <= b_ldx;
    c_ldy <= b_ldy;
    c_bx <= b_bx;
    c_by <= b_by;
  end

  // Normalize signs so that d is positive, then test both ratios in [0,1].
  always_comb begin
    d_neg   = c_d[T-1];
    ad_full = d_neg ? -c_d : c_d;
    nl_ext  = $signed({c_nl[T-1], c_nl});
    nr_ext  = $signed({c_nr[T-1], c_nr});
    ad_ext  = $signed({1'b0, ad_full});
    nl_adj  = d_neg ? -nl_ext : nl_ext;
    nr_adj  = d_neg ? -nr_ext : nr_ext;
    in_l    = !nl_adj[T] && (ad_ext >= nl_adj);
    in_r    = !nr_adj[T] && (ad_ext >= nr_adj);
    hit_next = !c_reject && (c_d != '0) &&
               (ad_full[M-1:0] >= {{(M-L){1'b0}}, limit}) && in_l && in_r;
  end

  // Stage D: decision and magnitudes.
  always_ff @(posedge clk) begin
    tag.hit    <= hit_next;
    tag.neg_x  <= c_ldx[D-1];
    tag.neg_y  <= c_ldy[D-1];
    tag.base_x <= c_bx;
    tag.base_y <= c_by;
    nl_mag  <= nl_adj[M-1:0];
    det_mag <= ad_full[M-1:0];
    mag_x   <= c_ldx[D-1] ? -c_ldx : c_ldx;
    mag_y   <= c_ldy[D-1] ? -c_ldy : c_ldy;
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

endmodule

`default_nettype wire

### rtl/sgi_scale.sv
// ----------------------------------------------------------------------------
// sgi_scale
// Two-stage multiply of the first numerator by the segment extents, split
// into half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_scale (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  input  sgi_pkg::sgi_tag_t                  in_tag,
  input  wire  [sgi_pkg::MAG_BITS-1:0]       nl_mag,
  input  wire  [sgi_pkg::MAG_BITS-1:0]       in_det,
  input  wire  [sgi_pkg::DIFF_BITS-1:0]      mag_x,
  input  wire  [sgi_pkg::DIFF_BITS-1:0]      mag_y,
  output logic                               out_valid,
  output sgi_pkg::sgi_tag_t                  out_tag,
  output logic [sgi_pkg::MAG_BITS-1:0]       out_det,
  output logic [sgi_pkg::SCALE_BITS-1:0]     prod_x,
  output logic [sgi_pkg::SCALE_BITS-1:0]     prod_y
);

  localparam int D  = sgi_pkg::DIFF_BITS;
  localparam int M  = sgi_pkg::MAG_BITS;
  localparam int S  = sgi_pkg::SCALE_BITS;
  localparam int H  = M / 2;
  localparam int PP = H + D;

  logic                   s_valid;
  sgi_pkg::sgi_tag_t      s_tag;
  logic [M-1:0]           s_det;
  logic [PP-1:0]          hx, lx, hy, ly;

  // Stage 1: partial products of the high and low numerator halves.
  always_ff @(posedge clk) begin
    hx <= nl_mag[M-1:H] * mag_x;
    lx <= nl_mag[H-1:0] * mag_x;
    hy <= nl_mag[M-1:H] * mag_y;
    ly <= nl_mag[H-1:0] * mag_y;
    s_tag <= in_tag;
    s_det <= in_det;
  end

  // Stage 2: recombine the partial products.
  always_ff @(posedge clk) begin
    prod_x <= {hx, {H{1'b0}}} + {{(S-PP){1'b0}}, lx};
    prod_y <= {hy, {H{1'b0}}} + {{(S-PP){1'b0}}, ly};
    out_tag <= s_tag;
    out_det <= s_det;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s_valid   <= in_valid;
      out_valid <= s_valid;
    end
  end

endmodule

`default_nettype wire

### rtl/sgi_div.sv
// ----------------------------------------------------------------------------
// sgi_div
// Pipelined restoring divider for both axes: one quotient bit per stage,
// with the side information carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_div (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  input  sgi_pkg::sgi_tag_t                 in_tag,
  input  wire  [sgi_pkg::MAG_BITS-1:0]      det,
  input  wire  [sgi_pkg::SCALE_BITS-1:0]    num_x,
  input  wire  [sgi_pkg::SCALE_BITS-1:0]    num_y,
  output logic                              out_valid,
  output sgi_pkg::sgi_tag_t                 out_tag,
  output logic [sgi_pkg::QUO_BITS-1:0]      quo_x,
  output logic [sgi_pkg::QUO_BITS-1:0]      quo_y
);

  localparam int M = sgi_pkg::MAG_BITS;
  localparam int Q = sgi_pkg::QUO_BITS;

  // Per-stage pipeline registers; index 0 is the module input.
  logic              v   [0:Q];
  sgi_pkg::sgi_tag_t tg  [0:Q];
  logic [M-1:0]      dv  [0:Q];
  logic [M-1:0]      rx  [0:Q];
  logic [M-1:0]      ry  [0:Q];
  logic [Q-1:0]      lwx [0:Q];
  logic [Q-1:0]      lwy [0:Q];
  logic [Q-1:0]      qx  [0:Q];
  logic [Q-1:0]      qy  [0:Q];

  // The quotient fits in Q bits, so the upper numerator bits start below det.
  always_comb begin
    v[0]   = in_valid;
    tg[0]  = in_tag;
    dv[0]  = det;
    rx[0]  = num_x[M+Q-1:Q];
    ry[0]  = num_y[M+Q-1:Q];
    lwx[0] = num_x[Q-1:0];
    lwy[0] = num_y[Q-1:0];
    qx[0]  = '0;
    qy[0]  = '0;
  end

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [M:0] tx, ty, sx, sy;
    logic       gex, gey;

    // Bring down the next numerator bit and try one subtraction per axis.
    always_comb begin
      tx  = {rx[k], lwx[k][Q-1]};
      ty  = {ry[k], lwy[k][Q-1]};
      sx  = tx - {1'b0, dv[k]};
      sy  = ty - {1'b0, dv[k]};
      gex = (tx >= {1'b0, dv[k]});
      gey = (ty >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      rx[k+1]  <= gex ? sx[M-1:0] : tx[M-1:0];
      ry[k+1]  <= gey ? sy[M-1:0] : ty[M-1:0];
      lwx[k+1] <= {lwx[k][Q-2:0], 1'b0};
      lwy[k+1] <= {lwy[k][Q-2:0], 1'b0};
      qx[k+1]  <= {qx[k][Q-2:0], gex};
      qy[k+1]  <= {qy[k][Q-2:0], gey};
      dv[k+1]  <= dv[k];
      tg[k+1]  <= tg[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end
  end

  assign out_valid = v[Q];
  assign out_tag   = tg[Q];
  assign quo_x     = qx[Q];
  assign quo_y     = qy[Q];

endmodule

`default_nettype wire
